[design/ter_pkg.sv]
`default_nettype none

package ter_pkg;

	localparam int CANVAS_SIZE_DEF = 1024;
	localparam int COORD_BITS_DEF  = 16;

	// Command codes on the request channel.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// Edge numbers, in walking order.
	localparam logic [1:0] EDGE_01 = 2'd0;
	localparam logic [1:0] EDGE_12 = 2'd1;
	localparam logic [1:0] EDGE_02 = 2'd2;

	typedef enum logic [1:0] {
		MODE_VERT    = 2'd0,
		MODE_SHALLOW = 2'd1,
		MODE_STEEP   = 2'd2
	} mode_t;

	typedef struct packed {
		logic               command;
		logic signed [15:0] vert0_x;
		logic signed [15:0] vert0_y;
		logic signed [15:0] vert1_x;
		logic signed [15:0] vert1_y;
		logic signed [15:0] vert2_x;
		logic signed [15:0] vert2_y;
	} tri_req_t;

	typedef struct packed {
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic               inside_res;
		logic [1:0]         edge_number;
		logic               last;
	} pix_res_t;

endpackage

`default_nettype wire

[design/triangle_edge_rasterizer_unit.sv]
`default_nettype none

// Channel   Direction  Handshake              Payload
// request   in         req_valid / req_ready  req (tri_req_t)
// pixel     out        pix_valid / pix_ready  pix (pix_res_t)
//
// Each request is taken into an input register; a step's pixel then goes to the pixel
// register. One request is taken per cycle unless a stalled pixel register holds a step.
// The edge set-up and the error update sit between the input and the pixel register.
// Reset empties both registers and leaves the block idle with no triangle loaded.
// A stalled pixel register holds up step requests only; loads and idle steps pass.

module triangle_edge_rasterizer_unit
	import ter_pkg::*;
#(
	parameter int CANVAS_SIZE = CANVAS_SIZE_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire tri_req_t req,
	output logic          pix_valid,
	input  wire logic     pix_ready,
	output pix_res_t      pix
);

	localparam int CW  = COORD_BITS;
	localparam int SPW = CW + 1;
	localparam int EW  = CW + 3;
	localparam logic signed [33:0] CANVAS_L = 34'(CANVAS_SIZE);

	tri_req_t req_s1;
	logic     valid_s1;
	logic     busy_q;
	logic     pix_valid_q;
	pix_res_t pix_q;

	logic signed [CW-1:0] vert_q [6];
	logic [1:0]           edge_q;
	mode_t                mode_q;
	logic [SPW-1:0]       idx_q;
	logic [SPW-1:0]       total_q;
	logic signed [CW-1:0] run_x_q;
	logic signed [CW-1:0] run_y_q;
	logic [SPW-1:0]       major_q;
	logic [SPW-1:0]       minor_q;
	logic                 down_q;
	logic [EW-1:0]        err_q;

	logic slot_free, proc, do_load, do_step, at_end, do_next_edge, setup_en;
	logic [1:0] se;
	logic signed [CW-1:0] vin [6];
	logic signed [CW-1:0] vsrc [6];
	logic signed [CW-1:0] ax, ay, bx, by;
	logic signed [CW:0]   d1, d2;
	logic [SPW-1:0]       adx, ady;
	mode_t                su_mode;
	logic signed [CW-1:0] su_x, su_y;
	logic [SPW-1:0]       su_major, su_minor;
	logic                 su_down;
	logic [EW-1:0]        su_err;
	logic [EW-1:0]        inc, lim, err_sum;
	logic [EW:0]          err_diff;
	logic                 err_wrap;
	logic signed [CW-1:0] y_next;
	logic signed [33:0]   xe, ye;
	pix_res_t             res;

	assign slot_free    = !pix_valid_q || pix_ready;
	assign proc         = valid_s1 && (req_s1.command == CMD_LOAD || !busy_q || slot_free);
	assign do_load      = proc && req_s1.command == CMD_LOAD;
	assign do_step      = proc && req_s1.command == CMD_STEP && busy_q;
	assign at_end       = idx_q >= total_q;
	assign do_next_edge = do_step && at_end && edge_q != EDGE_02;
	assign setup_en     = do_load || do_next_edge;
	assign se           = do_load ? EDGE_01 : edge_q + 2'd1;

	assign req_ready = !valid_s1 || proc;
	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

	// The 16-bit fields are read as COORD_BITS-bit two's complement values.
	always_comb begin
		logic [31:0] raw [6];
		raw[0] = {16'b0, req_s1.vert0_x};
		raw[1] = {16'b0, req_s1.vert0_y};
		raw[2] = {16'b0, req_s1.vert1_x};
		raw[3] = {16'b0, req_s1.vert1_y};
		raw[4] = {16'b0, req_s1.vert2_x};
		raw[5] = {16'b0, req_s1.vert2_y};
		for (int i = 0; i < 6; i++) begin
			vin[i]  = raw[i][CW-1:0];
			vsrc[i] = do_load ? vin[i] : vert_q[i];
		end
	end

	// Edge set-up: pick the endpoints, then order them left to right.
	always_comb begin
		ax = (se == EDGE_12) ? vsrc[2] : vsrc[0];
		ay = (se == EDGE_12) ? vsrc[3] : vsrc[1];
		bx = (se == EDGE_01) ? vsrc[2] : vsrc[4];
		by = (se == EDGE_01) ? vsrc[3] : vsrc[5];
		d1 = {bx[CW-1], bx} - {ax[CW-1], ax};
		d2 = {by[CW-1], by} - {ay[CW-1], ay};
		adx = d1[CW] ? SPW'(-d1) : SPW'(d1);
		ady = d2[CW] ? SPW'(-d2) : SPW'(d2);
		if (d1 == '0) begin
			su_mode  = MODE_VERT;
			su_x     = ax;
			su_y     = d2[CW] ? by : ay;
			su_major = ady;
			su_minor = '0;
			su_down  = 1'b0;
			su_err   = '0;
		end else begin
			su_x    = d1[CW] ? bx : ax;
			su_y    = d1[CW] ? by : ay;
			// y falls along the edge when the two differences have opposite signs.
			su_down = (d2 != '0) && (d1[CW] != d2[CW]);
			if (ady <= adx) begin
				su_mode  = MODE_SHALLOW;
				su_major = adx;
				su_minor = ady;
				su_err   = su_down ? {2'b0, adx} - EW'(1) : '0;
			end else begin
				su_mode  = MODE_STEEP;
				su_major = ady;
				su_minor = adx;
				su_err   = {2'b0, ady};
			end
		end
	end

	// One step of the DDA; the steep case works in doubled units for the half-up rounding.
	always_comb begin
		inc      = (mode_q == MODE_STEEP) ? {1'b0, minor_q, 1'b0} : {2'b0, minor_q};
		lim      = (mode_q == MODE_STEEP) ? {1'b0, major_q, 1'b0} : {2'b0, major_q};
		err_sum  = err_q + inc;
		err_diff = {1'b0, err_sum} - {1'b0, lim};
		err_wrap = !err_diff[EW];
		y_next   = down_q ? run_y_q - CW'(1) : run_y_q + CW'(1);
	end

	always_comb begin
		xe = {{(34-CW){run_x_q[CW-1]}}, run_x_q};
		ye = {{(34-CW){run_y_q[CW-1]}}, run_y_q};
		res.pixel_x     = xe[15:0];
		res.pixel_y     = ye[15:0];
		res.inside_res  = !xe[33] && xe < CANVAS_L && !ye[33] && ye < CANVAS_L;
		res.edge_number = edge_q;
		res.last        = at_end && edge_q == EDGE_02;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			busy_q      <= 1'b0;
			pix_valid_q <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (do_load) begin
				busy_q <= 1'b1;
			end else if (do_step && at_end && edge_q == EDGE_02) begin
				busy_q <= 1'b0;
			end
			if (do_step) begin
				pix_valid_q <= 1'b1;
			end else if (pix_ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (do_step) begin
			pix_q <= res;
		end
		if (do_load) begin
			for (int i = 0; i < 6; i++) begin
				vert_q[i] <= vin[i];
			end
		end
		if (setup_en) begin
			edge_q  <= se;
			mode_q  <= su_mode;
			idx_q   <= '0;
			total_q <= su_major;
			run_x_q <= su_x;
			run_y_q <= su_y;
			major_q <= su_major;
			minor_q <= su_minor;
			down_q  <= su_down;
			err_q   <= su_err;
		end else if (do_step && !at_end) begin
			idx_q <= idx_q + SPW'(1);
			unique case (mode_q)
				MODE_VERT: begin
					run_y_q <= run_y_q + CW'(1);
				end
				MODE_SHALLOW: begin
					run_x_q <= run_x_q + CW'(1);
					err_q   <= err_wrap ? err_diff[EW-1:0] : err_sum;
					if (err_wrap) begin
						run_y_q <= y_next;
					end
				end
				MODE_STEEP: begin
					run_y_q <= y_next;
					err_q   <= err_wrap ? err_diff[EW-1:0] : err_sum;
					if (err_wrap) begin
						run_x_q <= run_x_q + CW'(1);
					end
				end
				default: begin
					run_y_q <= run_y_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[tb/tb_triangle_edge_rasterizer_unit.sv]
`timescale 1ns / 1ps

module tb_triangle_edge_rasterizer_unit;
	import ter_pkg::*;

	localparam int N_ITEMS        = 450;
	localparam int QUIET_ITEMS    = 80;
	localparam int DRAIN_AT       = 220;
	localparam int LONG_HOLD      = 300;
	localparam int HOLD_AFTER     = 60;
	localparam int TAIL_CYCLES    = 20;
	localparam int TIMEOUT_CYCLES = 200000;
	localparam int MAX_PRINTS     = 20;

	// Walks the outline of the loaded triangle and queues the pixel each step transfer yields.
	class pixel_scoreboard;
		pix_res_t expected_q[$];
		int       failures;
		bit       walking;
		int       vert[6];
		logic [1:0] edge_sel;
		mode_t    mode;
		int       idx, total, cur_x, cur_y, major, minor, err;
		bit       down;

		function new();
			failures = 0;
			walking  = 1'b0;
			foreach (vert[i]) vert[i] = 0;
			edge_sel = EDGE_01;
			mode     = MODE_VERT;
			idx = 0; total = 0; cur_x = 0; cur_y = 0;
			major = 0; minor = 0; err = 0; down = 1'b0;
		endfunction

		task report(string what);
			failures++;
			if (failures <= MAX_PRINTS) $display("MISMATCH %s", what);
		endtask

		function int pending();
			return expected_q.size();
		endfunction

		function void setup_edge(logic [1:0] e);
			int ia, ib, ax, ay, bx, by, dx, dy, ady, t;
			ia = (e == EDGE_12) ? 1 : 0;
			ib = (e == EDGE_01) ? 1 : 2;
			ax = vert[2 * ia];
			ay = vert[2 * ia + 1];
			bx = vert[2 * ib];
			by = vert[2 * ib + 1];
			edge_sel = e;
			idx = 0;
			err = 0;
			if (ax == bx) begin
				mode  = MODE_VERT;
				cur_x = ax;
				cur_y = (ay < by) ? ay : by;
				total = (ay < by) ? by - ay : ay - by;
				major = total;
				minor = 0;
				down  = 1'b0;
				return;
			end
			// Every sloped edge is walked from its left end.
			if (bx < ax) begin
				t = ax; ax = bx; bx = t;
				t = ay; ay = by; by = t;
			end
			dx    = bx - ax;
			dy    = by - ay;
			ady   = (dy < 0) ? -dy : dy;
			cur_x = ax;
			cur_y = ay;
			down  = (dy < 0);
			if (ady <= dx) begin
				mode  = MODE_SHALLOW;
				major = dx;
				minor = ady;
				err   = down ? major - 1 : 0;
			end else begin
				mode  = MODE_STEEP;
				major = ady;
				minor = dx;
				err   = major;
			end
			total = major;
		endfunction

		function void advance();
			idx++;
			case (mode)
				MODE_VERT: begin
					cur_y++;
				end
				MODE_SHALLOW: begin
					cur_x++;
					err += minor;
					if (err >= major) begin
						err -= major;
						cur_y += down ? -1 : 1;
					end
				end
				default: begin
					cur_y += down ? -1 : 1;
					err += 2 * minor;
					if (err >= 2 * major) begin
						err -= 2 * major;
						cur_x++;
					end
				end
			endcase
		endfunction

		function void note_request(tri_req_t r);
			pix_res_t want;
			if (r.command == CMD_LOAD) begin
				vert[0] = r.vert0_x; vert[1] = r.vert0_y;
				vert[2] = r.vert1_x; vert[3] = r.vert1_y;
				vert[4] = r.vert2_x; vert[5] = r.vert2_y;
				walking = 1'b1;
				setup_edge(EDGE_01);
				return;
			end
			if (!walking) return;
			want.pixel_x     = cur_x[15:0];
			want.pixel_y     = cur_y[15:0];
			want.inside_res  = (cur_x >= 0 && cur_x < CANVAS_SIZE_DEF &&
				cur_y >= 0 && cur_y < CANVAS_SIZE_DEF);
			want.edge_number = edge_sel;
			want.last        = 1'b0;
			if (idx >= total) begin
				if (edge_sel == EDGE_02) begin
					want.last = 1'b1;
					walking   = 1'b0;
				end else begin
					setup_edge(edge_sel + 2'd1);
				end
			end else begin
				advance();
			end
			expected_q.push_back(want);
		endfunction

		task check_pixel(pix_res_t got);
			pix_res_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("pixel (%0d,%0d) edge %0d with nothing expected",
					got.pixel_x, got.pixel_y, got.edge_number));
				return;
			end
			want = expected_q.pop_front();
			if (got.pixel_x !== want.pixel_x)
				report($sformatf("pixel_x %0d, expected %0d", got.pixel_x, want.pixel_x));
			if (got.pixel_y !== want.pixel_y)
				report($sformatf("pixel_y %0d, expected %0d", got.pixel_y, want.pixel_y));
			if (got.inside_res !== want.inside_res)
				report($sformatf("inside_res %b, expected %b at (%0d,%0d)",
					got.inside_res, want.inside_res, want.pixel_x, want.pixel_y));
			if (got.edge_number !== want.edge_number)
				report($sformatf("edge_number %0d, expected %0d",
					got.edge_number, want.edge_number));
			if (got.last !== want.last)
				report($sformatf("last %b, expected %b at (%0d,%0d)",
					got.last, want.last, want.pixel_x, want.pixel_y));
		endtask
	endclass

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	tri_req_t req       = '0;
	logic     pix_valid;
	logic     pix_ready = 1'b0;
	pix_res_t pix;

	pixel_scoreboard sb = new();
	int items_sent = 0;
	int gap_pct    = 20;
	bit quiet      = 1'b0;

	triangle_edge_rasterizer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic tri_req_t junk_step();
		logic [127:0] bits;
		tri_req_t     r;
		bits      = {$urandom, $urandom, $urandom, $urandom};
		r         = bits[$bits(tri_req_t)-1:0];
		r.command = CMD_STEP;
		return r;
	endfunction

	function automatic int pick_base();
		case ($urandom_range(0, 4))
			0:       return int'($urandom_range(0, 20)) - 10;
			1:       return CANVAS_SIZE_DEF + int'($urandom_range(0, 20)) - 10;
			2:       return -32768 + int'($urandom_range(0, 6));
			3:       return 32767 - int'($urandom_range(0, 6));
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	function automatic int near_coord(int base, int spread);
		int v;
		v = base + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < -32768) v = -32768;
		if (v > 32767) v = 32767;
		return v;
	endfunction

	// Holds valid and payload until the transfer, then notes it and sometimes idles.
	task automatic offer(input tri_req_t item);
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sb.note_request(item);
		items_sent++;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic load_tri(input int x0, y0, x1, y1, x2, y2);
		tri_req_t r;
		r         = junk_step();
		r.command = CMD_LOAD;
		r.vert0_x = x0[15:0]; r.vert0_y = y0[15:0];
		r.vert1_x = x1[15:0]; r.vert1_y = y1[15:0];
		r.vert2_x = x2[15:0]; r.vert2_y = y2[15:0];
		offer(r);
	endtask

	task automatic walk(input int n);
		repeat (n) offer(junk_step());
	endtask

	task automatic walk_out();
		while (sb.walking) offer(junk_step());
	endtask

	task automatic small_triangle();
		int bx, by, spread;
		bx     = pick_base();
		by     = pick_base();
		spread = $urandom_range(0, 4);
		load_tri(near_coord(bx, spread), near_coord(by, spread),
			near_coord(bx, spread), near_coord(by, spread),
			near_coord(bx, spread), near_coord(by, spread));
	endtask

	initial begin
		int kind;
		bit drained;
		drained = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Step with nothing loaded, then a triangle collapsed onto one pixel.
		offer(junk_step());
		load_tri(1023, 1023, 1023, 1023, 1023, 1023);
		walk(3);
		// Corners of the coordinate range; abandoned part way along the first edge.
		load_tri(-32768, 32767, 32767, -32768, -32768, -32768);
		walk(2);
		// Vertical edge, then shallow up and down, across the right border of the canvas.
		load_tri(1023, 2, 1023, 0, 1025, 1);
		walk_out();
		// Steep edge given right to left, shallow down, and a diagonal.
		load_tri(0, -1, -1, 1, 1, 0);
		walk_out();

		while (items_sent < N_ITEMS) begin
			if (items_sent >= N_ITEMS - QUIET_ITEMS) quiet = 1'b1;
			if (!drained && items_sent >= DRAIN_AT) begin
				drained = 1'b1;
				req_valid <= 1'b0;
				do @(posedge clk); while (sb.pending() != 0);
			end
			case ($urandom_range(0, 3))
				0:       gap_pct = 0;
				1:       gap_pct = 10;
				2:       gap_pct = 30;
				default: gap_pct = 60;
			endcase
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				small_triangle();
				walk_out();
				walk($urandom_range(0, 1));
			end else if (kind == 6) begin
				small_triangle();
				walk($urandom_range(0, 6));
			end else if (kind == 7) begin
				load_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				walk($urandom_range(1, 8));
			end else begin
				walk($urandom_range(1, 3));
			end
		end

		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d pixels never arrived", sb.pending()));
		if (sb.failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		int stall_left, seen;
		bit held;
		stall_left = 0;
		seen       = 0;
		held       = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pix_valid && pix_ready) begin
				sb.check_pixel(pix);
				seen++;
			end
			// One long hold-off lets the block fill up and refuse step transfers.
			if (!held && seen == HOLD_AFTER) begin
				held = 1'b1;
				pix_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (stall_left > 0) begin
				pix_ready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 99) < 12) begin
				pix_ready <= 1'b0;
				stall_left = $urandom_range(1, 10) - 1;
			end else begin
				pix_ready <= 1'b1;
			end
		end
	end

	initial begin
		#(2 * TIMEOUT_CYCLES);
		$display("tb: failure");
		$finish;
	end

endmodule
